// ===== sv/kctle_pkg.sv =====
// Package for the key code text line editor.
// Holds the key map, character codes and event codes; no dependencies.
package kctle_pkg;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNKNOWN = 8'h3F;
    localparam logic [7:0] CH_ESC     = 8'h51;  // 'Q'
    localparam logic [7:0] CH_BS      = 8'h42;  // 'B'
    localparam logic [7:0] CH_TAB     = 8'h54;  // 'T'
    localparam logic [7:0] CH_ENTER   = 8'h45;  // 'E'
    localparam logic [7:0] CH_UP      = 8'h55;  // 'U'
    localparam logic [7:0] CH_RIGHT   = 8'h52;  // 'R'
    localparam logic [7:0] CH_LEFT    = 8'h44;  // 'D'

    localparam logic [4:0] EV_KEY   = 5'd1;
    localparam logic [1:0] KV_PRESS = 2'd1;
    localparam int unsigned DISP_COLS = 16;

    typedef logic [7:0] t_char;

    // map a scan code to its character, zero when unmapped
    function automatic t_char key_map(input logic [7:0] code);
        t_char ch;
        case (code)
            8'd1:   ch = "Q";
            8'd2:   ch = "1";
            8'd3:   ch = "2";
            8'd4:   ch = "3";
            8'd5:   ch = "4";
            8'd6:   ch = "5";
            8'd7:   ch = "6";
            8'd8:   ch = "7";
            8'd9:   ch = "8";
            8'd10:  ch = "9";
            8'd11:  ch = "0";
            8'd12:  ch = "-";
            8'd13:  ch = "=";
            8'd14:  ch = "B";
            8'd15:  ch = "T";
            8'd16:  ch = "q";
            8'd17:  ch = "w";
            8'd18:  ch = "e";
            8'd19:  ch = "r";
            8'd20:  ch = "t";
            8'd21:  ch = "y";
            8'd22:  ch = "u";
            8'd23:  ch = "i";
            8'd24:  ch = "o";
            8'd25:  ch = "p";
            8'd26:  ch = "[";
            8'd27:  ch = "]";
            8'd28:  ch = "E";
            8'd30:  ch = "a";
            8'd31:  ch = "s";
            8'd32:  ch = "d";
            8'd33:  ch = "f";
            8'd34:  ch = "g";
            8'd35:  ch = "h";
            8'd36:  ch = "j";
            8'd37:  ch = "k";
            8'd38:  ch = "l";
            8'd44:  ch = "z";
            8'd45:  ch = "x";
            8'd46:  ch = "c";
            8'd47:  ch = "v";
            8'd48:  ch = "b";
            8'd49:  ch = "n";
            8'd50:  ch = "m";
            8'd51:  ch = ",";
            8'd52:  ch = ".";
            8'd53:  ch = "/";
            8'd57:  ch = " ";
            8'd103: ch = "U";
            8'd108: ch = "D";
            8'd106: ch = "R";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/keycode_text_line_editor.sv =====
// Key code text line editor: edit line in a synchronous memory, display cell stream out.
// Depends on kctle_pkg.
//
// channel  dir  tdata (low bit up)                          tuser / tlast
// s_axis   in   key_code[7:0], key_value[9:8]               tuser: mode[0], event_type[5:1]
// m_axis   out  write_valid[0], row[1], column[5:2],        tlast: last item of an input
//               char_out[13:6], cursor_now[18:14], editing_now[19]
//
// A status item is answered directly from idle. An edit key updates the line (tab then
// writes spaces in S_TAB) and walks min(LINE_LEN,16) displayed cells; enter walks two rows.
// Each cell is one read of the line memory, then one load of the output register.
// Reset clears per-entry valid bits (line reads as spaces), cursor and editing flag.
// Output stalls hold the walk; a new input is taken only once the walk is done.
module keycode_text_line_editor #(
    parameter int LINE_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key_code, key_value
    input  logic [5:0]  s_axis_tuser,   // mode, event_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // write_valid, row, column, char_out, cursor_now,
                                        // editing_now, zero fill
    output logic        m_axis_tlast
);

    localparam int AW   = $clog2(LINE_LEN);
    localparam int CUW  = $clog2(LINE_LEN + 1);
    localparam int NCOL = (LINE_LEN < kctle_pkg::DISP_COLS) ? LINE_LEN : kctle_pkg::DISP_COLS;
    localparam logic [3:0]     LAST_COL = 4'(NCOL - 1);
    localparam logic [CUW-1:0] CUR_MAX  = CUW'(LINE_LEN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAB  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    logic [7:0]          r_mem [LINE_LEN];
    logic [LINE_LEN-1:0] r_vld;
    logic [7:0]          r_rdata;
    logic                r_rdv;

    logic [1:0]     r_state;
    logic [CUW-1:0] r_cursor;
    logic           r_edit;
    logic           r_row;
    logic [3:0]     r_col;
    logic [1:0]     r_tab_cnt;

    logic       r_ov;
    logic       r_o_wv;
    logic       r_o_row;
    logic [3:0] r_o_col;
    logic [7:0] r_o_ch;
    logic       r_o_last;

    logic          w_ofree;
    logic          w_acc;
    logic          w_mode;
    logic [4:0]    w_etype;
    logic [7:0]    w_code;
    logic [1:0]    w_value;
    kctle_pkg::t_char w_map;
    kctle_pkg::t_char w_ch;
    logic          w_status;
    logic          w_oload;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_rd_addr;
    logic          w_cur_lt;
    logic          w_cur_gt0;

    assign w_ofree   = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_ofree;
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_mode    = s_axis_tuser[0];
    assign w_etype   = s_axis_tuser[5:1];
    assign w_code    = s_axis_tdata[7:0];
    assign w_value   = s_axis_tdata[9:8];
    assign w_map     = kctle_pkg::key_map(w_code);
    assign w_ch      = (w_map == 8'h00) ? kctle_pkg::CH_UNKNOWN : w_map;
    assign w_status  = w_mode || !r_edit || w_etype != kctle_pkg::EV_KEY ||
                       w_value != kctle_pkg::KV_PRESS;
    assign w_oload   = (r_state == S_IDLE && w_acc && w_status) ||
                       (r_state == S_WR && w_ofree);
    assign w_cur_lt  = r_cursor < CUR_MAX;
    assign w_cur_gt0 = r_cursor != '0;
    assign w_rd_addr = AW'(r_col);

    // single write port: inserts, backspace blanks and tab spaces
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_cursor);
        if (r_state == S_TAB) begin
            w_we = w_cur_lt;
        end else if (w_acc && !w_status) begin
            case (w_ch)
                kctle_pkg::CH_ESC, kctle_pkg::CH_TAB, kctle_pkg::CH_ENTER,
                kctle_pkg::CH_UP, kctle_pkg::CH_RIGHT, kctle_pkg::CH_LEFT: begin
                    w_we = 1'b0;
                end
                kctle_pkg::CH_BS: begin
                    w_we    = w_cur_gt0;
                    w_waddr = AW'(r_cursor - CUW'(1));
                end
                default: begin
                    w_we = w_cur_lt;
                end
            endcase
        end
    end

    // line memory: tab and backspace write spaces, inserts write the key character
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            if (r_state == S_TAB || w_ch == kctle_pkg::CH_BS) begin
                r_mem[w_waddr] <= kctle_pkg::CH_SPACE;
            end else begin
                r_mem[w_waddr] <= w_ch;
            end
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[w_rd_addr];
            r_rdv   <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cursor  <= '0;
            r_edit    <= 1'b0;
            r_vld     <= '0;
            r_row     <= 1'b1;
            r_col     <= '0;
            r_tab_cnt <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_col <= '0;
                        if (w_status) begin
                            if (w_mode) begin
                                r_edit <= !r_edit;
                            end
                            r_o_wv   <= 1'b0;
                            r_o_row  <= 1'b0;
                            r_o_col  <= '0;
                            r_o_ch   <= '0;
                            r_o_last <= 1'b1;
                        end else begin
                            r_row   <= (w_ch != kctle_pkg::CH_ENTER);
                            r_state <= (w_ch == kctle_pkg::CH_TAB) ? S_TAB : S_RD;
                            case (w_ch)
                                kctle_pkg::CH_ESC: begin
                                    r_vld    <= '0;
                                    r_cursor <= '0;
                                    r_edit   <= 1'b0;
                                end
                                kctle_pkg::CH_BS: begin
                                    if (w_cur_gt0) begin
                                        r_cursor <= r_cursor - CUW'(1);
                                    end
                                end
                                kctle_pkg::CH_TAB: begin
                                    r_tab_cnt <= '0;
                                end
                                kctle_pkg::CH_ENTER: begin
                                    r_cursor <= '0;
                                end
                                kctle_pkg::CH_UP, kctle_pkg::CH_RIGHT: begin
                                    if (w_cur_lt) begin
                                        r_cursor <= r_cursor + CUW'(1);
                                    end
                                end
                                kctle_pkg::CH_LEFT: begin
                                    if (w_cur_gt0) begin
                                        r_cursor <= r_cursor - CUW'(1);
                                    end
                                end
                                default: begin
                                    if (w_cur_lt) begin
                                        r_cursor <= r_cursor + CUW'(1);
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_TAB: begin
                    if (w_cur_lt) begin
                        r_cursor <= r_cursor + CUW'(1);
                    end
                    r_tab_cnt <= r_tab_cnt + 2'd1;
                    if (r_tab_cnt == 2'd3) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (w_ofree) begin
                        r_o_wv   <= 1'b1;
                        r_o_row  <= r_row;
                        r_o_col  <= r_col;
                        r_o_ch   <= r_rdv ? r_rdata : kctle_pkg::CH_SPACE;
                        r_o_last <= r_row && (r_col == LAST_COL);
                        if (r_col == LAST_COL) begin
                            r_col <= '0;
                            if (!r_row) begin
                                // top row sent: clear the line, then show it
                                r_vld   <= '0;
                                r_row   <= 1'b1;
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_col   <= r_col + 4'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {4'd0, r_edit, 5'(r_cursor), r_o_ch, r_o_col, r_o_row, r_o_wv};

endmodule
